@@ design/nearest_palette_color_assert.svh @@
// ----------------------------------------------------------------------------
// nearest_palette_color_assert.svh
// assertion macros shared by the nearest palette color design
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define NPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/npc_pkg.sv @@
// ----------------------------------------------------------------------------
// npc_pkg
// shared constants and types of the nearest palette color search
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int COLOR_W = 24;
	localparam int CHAN_W = 8;
	localparam int OUT_W = 6;
	localparam int DIST_W = 18;
	localparam int SEL_W = 9;

	localparam logic [DIST_W-1:0] START_DIST = DIST_W'(3 * 255 * 255);
	localparam logic [OUT_W-1:0] BLACK_INDEX = OUT_W'(8'h0F);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic start;
		logic valid;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

endpackage

@@ design/npc_cell.sv @@
// ----------------------------------------------------------------------------
// npc_cell
// one palette entry of the rotating ring, loadable by index
// ----------------------------------------------------------------------------
module npc_cell (
	input  logic clk,
	input  logic load_en,
	input  logic shift_en,
	input  logic [npc_pkg::COLOR_W-1:0] load_word,
	input  logic [npc_pkg::COLOR_W-1:0] next_word,
	output logic [npc_pkg::COLOR_W-1:0] word
);
	import npc_pkg::*;

	logic [COLOR_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			word_q <= load_word;
		end else if (shift_en) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

@@ design/npc_dist.sv @@
// ----------------------------------------------------------------------------
// npc_dist
// squared rgb distance and running minimum over the scanned entries
// ----------------------------------------------------------------------------
module npc_dist (
	input  logic clk,
	input  logic arst_n,
	input  npc_pkg::scan_ctl_t ctl,
	input  logic [npc_pkg::CHAN_W-1:0] red,
	input  logic [npc_pkg::CHAN_W-1:0] green,
	input  logic [npc_pkg::CHAN_W-1:0] blue,
	input  logic [npc_pkg::COLOR_W-1:0] head_word,
	output logic [npc_pkg::IDX_W-1:0] best_idx
);
	import npc_pkg::*;

	localparam int SQ_W = 2 * CHAN_W;

	logic [CHAN_W-1:0] er, eg, eb;
	logic [CHAN_W-1:0] dr, dg, db;
	logic [SQ_W-1:0] sq_r_s1, sq_g_s1, sq_b_s1;
	logic [IDX_W-1:0] idx_s1;
	logic valid_s1;
	logic [DIST_W-1:0] sum_dist;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0] best_idx_q;

	assign er = head_word[3*CHAN_W-1:2*CHAN_W];
	assign eg = head_word[2*CHAN_W-1:CHAN_W];
	assign eb = head_word[CHAN_W-1:0];

	assign dr = (red >= er) ? (red - er) : (er - red);
	assign dg = (green >= eg) ? (green - eg) : (eg - green);
	assign db = (blue >= eb) ? (blue - eb) : (eb - blue);

	always_ff @(posedge clk) begin
		sq_r_s1 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s1 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s1 <= SQ_W'(db) * SQ_W'(db);
		idx_s1 <= ctl.idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	assign sum_dist = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);

	// strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			best_dist_q <= START_DIST;
			best_idx_q <= '0;
		end else if (valid_s1 && (sum_dist < best_dist_q)) begin
			best_dist_q <= sum_dist;
			best_idx_q <= idx_s1;
		end
	end

	assign best_idx = best_idx_q;

endmodule

@@ design/nearest_palette_color.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color
// nearest palette entry search over a ring of ENTRIES loadable cells
// a load word is taken while idle and writes its cell; it gives no result
// a query word yields its result after ST_SCAN, ST_DRAIN and ST_DONE, and the
// next word is taken once the result is loaded; the ring rotates once past
// one distance unit. a black query skips the scan and yields index 15; reset
// clears control only, palette cells are undefined until loaded
// ----------------------------------------------------------------------------
`include "nearest_palette_color_assert.svh"

module nearest_palette_color (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // entry_index, red, green, blue
	input  logic s_tuser,        // kind
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata   // color_index
);
	import npc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [1:0] state_q;
	logic [IDX_W-1:0] cnt_q;
	logic black_q;
	logic [CHAN_W-1:0] red_q, green_q, blue_q;
	logic m_tvalid_q;
	logic [OUT_W-1:0] color_index_q;

	logic [OUT_W-1:0] entry_index;
	logic [CHAN_W-1:0] red, green, blue;
	logic accept, load_hit, query_hit, is_black, out_load;
	logic [COLOR_W-1:0] words [ENTRIES];
	logic [IDX_W-1:0] best_idx;
	logic [IDX_W+OUT_W-1:0] best_wide;
	logic [OUT_W-1:0] result;
	scan_ctl_t ctl;

	assign entry_index = s_tdata[5:0];
	assign red = s_tdata[13:6];
	assign green = s_tdata[21:14];
	assign blue = s_tdata[29:22];

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign load_hit = accept && (s_tuser == KIND_LOAD);
	assign query_hit = accept && (s_tuser == KIND_QUERY);
	assign is_black = ({red, green, blue} == '0);

	// palette ring, cell 0 feeds the distance unit
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		localparam int NXT = (i + 1) % ENTRIES;
		logic ld_en;

		assign ld_en = load_hit && ({3'b000, entry_index} == SEL_W'(i));

		npc_cell u_cell (
			.clk       (clk),
			.load_en   (ld_en),
			.shift_en  (state_q == ST_SCAN),
			.load_word ({red, green, blue}),
			.next_word (words[NXT]),
			.word      (words[i])
		);
	end

	assign ctl.start = query_hit && !is_black;
	assign ctl.valid = (state_q == ST_SCAN);
	assign ctl.idx = cnt_q;

	npc_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.red       (red_q),
		.green     (green_q),
		.blue      (blue_q),
		.head_word (words[0]),
		.best_idx  (best_idx)
	);

	always_ff @(posedge clk) begin
		if (query_hit) begin
			red_q <= red;
			green_q <= green;
			blue_q <= blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			black_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (query_hit) begin
						black_q <= is_black;
						cnt_q <= '0;
						state_q <= is_black ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign best_wide = {{OUT_W{1'b0}}, best_idx};
	assign result = black_q ? BLACK_INDEX : best_wide[OUT_W-1:0];
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			color_index_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(8 - OUT_W){1'b0}}, color_index_q};

	`NPC_ASSERT_NEXT(a_scan_ends, (state_q == ST_SCAN) && (cnt_q == LAST_IDX),
		state_q == ST_DRAIN, "scan did not end after the last entry")
	`NPC_ASSERT_NEXT(a_black_short, query_hit && is_black,
		(state_q == ST_DONE) && black_q, "black query did not skip the scan")
	`NPC_ASSERT_NOW(a_result_src, $rose(m_tvalid_q),
		$past(state_q) == ST_DONE, "result word raised outside the done state")

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// nearest palette color search, self-checking stream testbench
// loads the whole palette before any query, then runs directed words (all-black
// table, black query, ties, channel extremes) and a random mix of loads and
// queries; a scoreboard predicts each color_index at input acceptance and
// checks results in order under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;
	import npc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_WORDS = 310;
	localparam int HOLD_AT_RESULT = 120;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_AT_WORD = 200;

	typedef struct {
		logic       kind;
		logic [5:0] entry;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		int         gap;
		bit         drain;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;   // entry_index, red, green, blue
	logic s_tuser = 1'b0;        // kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;         // color_index

	word_t word_q[$];
	logic [5:0] expected_index_q[$];
	logic [23:0] palette_ram [ENTRIES];

	word_t cur_word;
	word_t nxt_word;
	logic offer;
	logic [5:0] exp_index;
	int send_wait = 0;
	int recv_wait = 0;
	int hold_left = 0;
	int result_cnt = 0;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;
	int fill_cnt = 0;

	nearest_palette_color dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [5:0] nearest_index(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int best_dist;
		int cur_dist;
		int dr;
		int dg;
		int db;
		logic [5:0] best;
		if (r == 8'd0 && g == 8'd0 && b == 8'd0)
			return BLACK_INDEX;
		best = '0;
		best_dist = int'(START_DIST);
		for (int i = 0; i < ENTRIES; i++) begin
			dr = int'(r) - int'(palette_ram[i][23:16]);
			dg = int'(g) - int'(palette_ram[i][15:8]);
			db = int'(b) - int'(palette_ram[i][7:0]);
			cur_dist = dr * dr + dg * dg + db * db;
			// strictly smaller only, so ties keep the lowest index
			if (cur_dist < best_dist) begin
				best_dist = cur_dist;
				best = 6'(i);
			end
		end
		return best;
	endfunction

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_word(logic kind, logic [5:0] entry, logic [7:0] r,
		logic [7:0] g, logic [7:0] b, bit drain);
		word_t w;
		w.kind = kind;
		w.entry = entry;
		w.red = r;
		w.green = g;
		w.blue = b;
		// every fourth stretch of fifty words runs back to back
		w.gap = ((fill_cnt / 50) % 4 == 3) ? 0 : $urandom_range(0, 17);
		w.drain = drain;
		fill_cnt++;
		word_q.push_back(w);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				if (cur_word.kind == KIND_LOAD)
					palette_ram[cur_word.entry] = {cur_word.red, cur_word.green, cur_word.blue};
				else
					expected_index_q.push_back(
						nearest_index(cur_word.red, cur_word.green, cur_word.blue));
				offer = 1'b0;
				send_wait = (word_q.size() > 0) ? word_q[0].gap : 0;
			end
			if (!offer) begin
				if (send_wait > 0) begin
					send_wait = send_wait - 1;
				end else if (word_q.size() > 0 &&
					!(word_q[0].drain && expected_index_q.size() > 0)) begin
					nxt_word = word_q.pop_front();
					cur_word = nxt_word;
					s_tdata <= {2'b00, nxt_word.blue, nxt_word.green, nxt_word.red, nxt_word.entry};
					s_tuser <= nxt_word.kind;
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_index_q.size() == 0) begin
					$error("unexpected word: color_index actual %0d", m_tdata[5:0]);
					mismatch_cnt++;
				end else begin
					exp_index = expected_index_q.pop_front();
					if (m_tdata[5:0] !== exp_index) begin
						$error("color_index: expected %0d, actual %0d", exp_index, m_tdata[5:0]);
						mismatch_cnt++;
					end
				end
				result_cnt++;
				if (result_cnt == HOLD_AT_RESULT)
					hold_left = HOLD_CYCLES;
				recv_wait = ((result_cnt / 40) % 3 == 1) ? 0 : $urandom_range(0, 17);
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait = recv_wait - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[nearest_palette_color] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic kind;
		// all-black table: white sits exactly on the start bound
		for (int i = 0; i < ENTRIES; i++)
			add_word(KIND_LOAD, 6'(i), 8'd0, 8'd0, 8'd0, 1'b0);
		add_word(KIND_QUERY, 6'd63, 8'd255, 8'd255, 8'd255, 1'b0);
		add_word(KIND_QUERY, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_word(KIND_QUERY, 6'd21, 8'd0, 8'd0, 8'd1, 1'b0);

		// real palette with a duplicated color and pure white at the top
		for (int i = 0; i < ENTRIES; i++) begin
			if (i == 5 || i == 42)
				add_word(KIND_LOAD, 6'(i), 8'd10, 8'd200, 8'd30, 1'b0);
			else if (i == 63)
				add_word(KIND_LOAD, 6'(i), 8'd255, 8'd255, 8'd255, 1'b0);
			else
				add_word(KIND_LOAD, 6'(i), pick_channel(), pick_channel(), pick_channel(), 1'b0);
		end
		add_word(KIND_QUERY, 6'd0, 8'd10, 8'd200, 8'd30, 1'b0);
		add_word(KIND_QUERY, 6'd63, 8'd255, 8'd255, 8'd255, 1'b0);
		add_word(KIND_QUERY, 6'd1, 8'd255, 8'd0, 8'd0, 1'b0);
		add_word(KIND_QUERY, 6'd2, 8'd0, 8'd255, 8'd0, 1'b0);
		add_word(KIND_QUERY, 6'd4, 8'd0, 8'd0, 8'd255, 1'b0);
		add_word(KIND_QUERY, 6'd42, 8'd0, 8'd0, 8'd0, 1'b0);
		add_word(KIND_QUERY, 6'd8, 8'd128, 8'd128, 8'd128, 1'b0);
		add_word(KIND_QUERY, 6'd16, 8'd1, 8'd0, 8'd0, 1'b0);
		add_word(KIND_QUERY, 6'd32, 8'd254, 8'd1, 8'd127, 1'b0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			kind = ($urandom_range(0, 9) < 3) ? KIND_LOAD : KIND_QUERY;
			if (kind == KIND_QUERY && $urandom_range(0, 15) == 0)
				add_word(kind, 6'($urandom_range(0, 63)), 8'd0, 8'd0, 8'd0, n == DRAIN_AT_WORD);
			else
				add_word(kind, 6'($urandom_range(0, 63)), pick_channel(), pick_channel(),
					pick_channel(), n == DRAIN_AT_WORD);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (word_q.size() == 0 && !s_tvalid && expected_index_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[nearest_palette_color] OK");
		else
			$display("[nearest_palette_color] ERROR");
		$finish;
	end

endmodule
